/* design/mccp_pkg.sv */
// Package with the byte codes and parser state type of the MIDI control change parser.
`timescale 1ns / 1ps

package mccp_pkg;

   // Widths of the item fields.
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CHANNEL_W    = 4;
   localparam int unsigned CONTROLLER_W = 7;
   localparam int unsigned VALUE_W      = 7;

   // Byte codes on the MIDI link.
   localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
   localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;
   localparam logic [BYTE_W-1:0] REALTIME_LO = 8'hF8;
   localparam logic [BYTE_W-1:0] SYSTEM_LO   = 8'hF0;

   // High nibble of a control change status byte.
   localparam logic [3:0] CC_STATUS_HI = 4'hB;

   // Parser state, one-hot.
   typedef enum logic [2:0] {
      PS_IGNORE = 3'b001,
      PS_CTRL   = 3'b010,
      PS_VALUE  = 3'b100
   } parse_state_type;

endpackage

/* design/midi_control_change_parser_core.sv */
// MIDI control change parser with running status, system exclusive skip and realtime pass-over.
`timescale 1ns / 1ps

//  Channel   Direction  Ports                                           Meaning
//  req       in         req_valid, req_stall, req_rx_byte               one received MIDI byte
//  rsp       out        rsp_valid, rsp_stall, rsp_channel,              one completed control
//                       rsp_controller, rsp_cc_value                    change message
//
//  A byte is captured in the input register and decoded by the parser from there into the
//  result register, so one item per clock is sustained while the result is not stalled.
//  The parse state is updated for each byte as it is decoded, which sets that rate.
//  Reset is synchronous and active high; it clears the parse state and both valid flags.
//  A stalled result holds in the result register; the input register keeps taking bytes
//  until it is full too, and only then is req_stall raised.

module midi_control_change_parser_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mccp_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mccp_pkg::CHANNEL_W-1:0]       rsp_channel,
   output logic [mccp_pkg::CONTROLLER_W-1:0]    rsp_controller,
   output logic [mccp_pkg::VALUE_W-1:0]         rsp_cc_value
);

   // Input register.
   logic                                 s1_valid_ff, s1_valid_in;
   logic [mccp_pkg::BYTE_W-1:0]          s1_byte_ff;

   // Parser state.
   logic                                 in_sysex_ff, in_sysex_in;
   mccp_pkg::parse_state_type            parse_state_ff, parse_state_in;
   logic [mccp_pkg::CHANNEL_W-1:0]       cur_channel_ff, cur_channel_in;
   logic [mccp_pkg::CONTROLLER_W-1:0]    held_controller_ff, held_controller_in;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mccp_pkg::CHANNEL_W-1:0]       rsp_channel_ff;
   logic [mccp_pkg::CONTROLLER_W-1:0]    rsp_controller_ff;
   logic [mccp_pkg::VALUE_W-1:0]         rsp_cc_value_ff;

   logic advance;
   logic req_accept;
   logic emit;
   logic is_realtime, is_system, is_status;

   // The held byte moves on whenever the result register is free or being emptied.
   // This never creates a false drop: a byte that yields no result needs no room,
   // but keeping the rule uniform keeps the stall path short.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   // Byte classes.
   assign is_realtime = (s1_byte_ff >= mccp_pkg::REALTIME_LO);
   assign is_system   = (s1_byte_ff >= mccp_pkg::SYSTEM_LO) && !is_realtime;
   assign is_status   = s1_byte_ff[mccp_pkg::BYTE_W-1];

   // Parser update for the byte in the input register.
   always_comb begin
      in_sysex_in        = in_sysex_ff;
      parse_state_in     = parse_state_ff;
      cur_channel_in     = cur_channel_ff;
      held_controller_in = held_controller_ff;
      emit               = 1'b0;
      if (advance) begin
         if (in_sysex_ff) begin
            // Everything inside a system exclusive message is skipped until its end byte.
            if (s1_byte_ff == mccp_pkg::SYSEX_END) begin
               in_sysex_in = 1'b0;
            end
         end else if (is_realtime) begin
            // Realtime bytes may arrive anywhere and leave the parse untouched.
         end else if (is_system) begin
            // System common bytes cancel running status; a start byte opens sysex.
            if (s1_byte_ff == mccp_pkg::SYSEX_START) begin
               in_sysex_in = 1'b1;
            end
            parse_state_in = mccp_pkg::PS_IGNORE;
         end else if (is_status) begin
            cur_channel_in = s1_byte_ff[mccp_pkg::CHANNEL_W-1:0];
            parse_state_in = (s1_byte_ff[mccp_pkg::BYTE_W-1:mccp_pkg::CHANNEL_W]
                              == mccp_pkg::CC_STATUS_HI) ? mccp_pkg::PS_CTRL
                                                         : mccp_pkg::PS_IGNORE;
         end else begin
            case (parse_state_ff)
               mccp_pkg::PS_CTRL: begin
                  held_controller_in = s1_byte_ff[mccp_pkg::CONTROLLER_W-1:0];
                  parse_state_in     = mccp_pkg::PS_VALUE;
               end
               mccp_pkg::PS_VALUE: begin
                  // Second data byte completes the message; running status returns
                  // to waiting for the next controller byte.
                  parse_state_in = mccp_pkg::PS_CTRL;
                  emit           = 1'b1;
               end
               default: begin
                  // Data without a usable status is dropped.
               end
            endcase
         end
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         in_sysex_ff        <= 1'b0;
         parse_state_ff     <= mccp_pkg::PS_IGNORE;
         cur_channel_ff     <= '0;
         held_controller_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         s1_valid_ff        <= s1_valid_in;
         in_sysex_ff        <= in_sysex_in;
         parse_state_ff     <= parse_state_in;
         cur_channel_ff     <= cur_channel_in;
         held_controller_ff <= held_controller_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (emit) begin
         rsp_channel_ff    <= cur_channel_ff;
         rsp_controller_ff <= held_controller_ff;
         rsp_cc_value_ff   <= s1_byte_ff[mccp_pkg::VALUE_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_controller = rsp_controller_ff;
   assign rsp_cc_value   = rsp_cc_value_ff;

   // While inside sysex no running status may survive.
   a_sysex_ignores : assert property (@(posedge clock) disable iff (reset)
      in_sysex_ff |-> (parse_state_ff == mccp_pkg::PS_IGNORE))
      else $error("running status kept inside system exclusive");

   // A new result always leaves the parser waiting for the next controller byte.
   a_emit_state : assert property (@(posedge clock) disable iff (reset)
      emit |=> (parse_state_ff == mccp_pkg::PS_CTRL))
      else $error("parse state wrong after a completed control change");

   // The input side only stalls while a byte is held and cannot move on.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // A result is only produced when the result register has room.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("waiting result overwritten");

endmodule
